[sv/fbmpn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmpn_pkg
// Constants and tables shared by the fBm gradient noise pipeline.
// ----------------------------------------------------------------------------
package fbmpn_pkg;

	localparam logic [3:0]  OCT_RESET   = 4'd4;

	// lattice hash
	localparam logic [31:0] HASH_MX     = 32'd1619;
	localparam logic [31:0] HASH_MZ     = 32'd31337;
	localparam logic [31:0] HASH_C1     = 32'd15731;
	localparam logic [31:0] HASH_C2     = 32'd789221;
	localparam logic [31:0] HASH_C3     = 32'd1376312589;
	localparam logic [31:0] HASH_MASK   = 32'h7fff_ffff;
	localparam logic [31:0] HASH_TOP    = 32'h8000_0000;

	// gradient pick: floor(v / 100) as (v * RECIP100) >> RECIP_SH, exact for v < 25600
	localparam logic [14:0] GRAD_PICK   = 15'd25599;
	localparam logic [14:0] RECIP100    = 15'd20972;
	localparam int          RECIP_SH    = 21;

	localparam logic signed [17:0] GRAD_ONE  = 18'sd65536;
	localparam logic signed [17:0] GRAD_DIAG = 18'sd46341;
	localparam logic [16:0]        NOISE_SCALE = 17'd92681;

	// corner hash offsets: bit 0 steps x, bit 1 steps z
	function automatic logic [31:0] corner_add(input logic [1:0] c);
		logic [31:0] r;
		r = 32'd0;
		if (c[0]) r = r + HASH_MX;
		if (c[1]) r = r + HASH_MZ;
		return r;
	endfunction

	function automatic logic signed [17:0] grad_x(input logic [2:0] idx);
		logic signed [17:0] g;
		case (idx)
			3'd0: g = GRAD_ONE;
			3'd1: g = -GRAD_ONE;
			3'd2: g = 18'sd0;
			3'd3: g = 18'sd0;
			3'd4: g = GRAD_DIAG;
			3'd5: g = -GRAD_DIAG;
			3'd6: g = GRAD_DIAG;
			default: g = -GRAD_DIAG;
		endcase
		return g;
	endfunction

	function automatic logic signed [17:0] grad_z(input logic [2:0] idx);
		logic signed [17:0] g;
		case (idx)
			3'd0: g = 18'sd0;
			3'd1: g = 18'sd0;
			3'd2: g = GRAD_ONE;
			3'd3: g = -GRAD_ONE;
			3'd4: g = GRAD_DIAG;
			3'd5: g = GRAD_DIAG;
			3'd6: g = -GRAD_DIAG;
			default: g = -GRAD_DIAG;
		endcase
		return g;
	endfunction

endpackage

[sv/fbmpn_octave_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmpn_octave_cell
// One octave of gradient noise: hash, fade, dots, blend, accumulate.
// Hands the doubled coordinate and the running sum to the next cell.
// ----------------------------------------------------------------------------
module fbmpn_octave_cell #(
	parameter int FRAC_BITS = 16,
	parameter int ACC_W     = 28,
	parameter int OCT_IDX   = 0,
	parameter int OCT_W     = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [OCT_W-1:0]        oct_cnt,
	input  logic                    vld_i,
	input  logic [FRAC_BITS+31:0]   cx_i,
	input  logic [FRAC_BITS+31:0]   cz_i,
	input  logic signed [ACC_W-1:0] acc_i,
	output logic                    vld_o,
	output logic [FRAC_BITS+31:0]   cx_o,
	output logic [FRAC_BITS+31:0]   cz_o,
	output logic signed [ACC_W-1:0] acc_o
);

	localparam int F  = FRAC_BITS;
	localparam int CW = F + 32;
	localparam int L  = 17;
	localparam int BW = F + 6;
	localparam int FW = F + 6;
	localparam int VW = F + 4;
	localparam int PW = F + 20;
	localparam logic signed [63:0] ONE    = 64'sd1 <<< F;
	localparam logic signed [63:0] HALF   = 64'sd1 <<< (F - 1);
	localparam logic signed [63:0] HALF16 = 64'sd32768;
	localparam logic [63:0]        HALFU  = 64'd1 << (F - 1);
	localparam logic [OCT_W:0]     IDX_C  = (OCT_W + 1)'(OCT_IDX);

	logic                    vld_q [L];
	logic [CW-1:0]           cx_q  [L];
	logic [CW-1:0]           cz_q  [L];
	logic signed [ACC_W-1:0] acc_q [L-1];

	logic [31:0]             hx_s1, hz_s1;
	logic signed [2*F+5:0]   pa_s1 [2];
	logic [2*F-1:0]          pt_s1 [2];
	logic [31:0]             n_s2  [4];
	logic signed [BW-1:0]    b_s2  [2];
	logic [F:0]              t2_s2 [2];
	logic [31:0]             sq_s3 [4];
	logic [31:0]             n_s3  [4];
	logic [2*F:0]            p3_s3 [2];
	logic signed [BW-1:0]    b_s3  [2];
	logic [31:0]             u_s4  [4];
	logic [31:0]             n_s4  [4];
	logic [F:0]              t3_s4 [2];
	logic signed [BW-1:0]    b_s4  [2];
	logic [31:0]             w_s5  [4];
	logic signed [2*F+7:0]   pf_s5 [2];
	logic [31:0]             e_s6  [4];
	logic signed [FW-1:0]    f_s6  [2];
	logic [15:0]             v_s7  [4];
	logic signed [FW-1:0]    f_s7  [2];
	logic [2:0]              idx_s8 [4];
	logic signed [FW-1:0]    f_s8  [2];
	logic signed [PW-1:0]    px_s9 [4];
	logic signed [PW-1:0]    pz_s9 [4];
	logic signed [FW-1:0]    f_s9  [2];
	logic signed [VW-1:0]    dot_s10 [4];
	logic signed [FW-1:0]    f_s10 [2];
	logic signed [VW:0]      d_s11 [2];
	logic signed [VW-1:0]    base_s11 [2];
	logic signed [FW-1:0]    f_s11 [2];
	logic signed [FW+VW:0]   m_s12 [2];
	logic signed [VW-1:0]    base_s12 [2];
	logic signed [FW-1:0]    fz_s12;
	logic signed [VW-1:0]    r_s13 [2];
	logic signed [FW-1:0]    fz_s13;
	logic signed [FW+VW:0]   mz_s14;
	logic signed [VW-1:0]    r0_s14;
	logic signed [VW-1:0]    r_s15;
	logic signed [VW+17:0]   rn_s16;
	logic signed [ACC_W-1:0] acc_s17;

	logic active;
	assign active = IDX_C < {1'b0, oct_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < L; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= vld_i;
			for (int k = 1; k < L; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin : p_data
		logic [F-1:0]       tt;
		logic [31:0]        nsum, nn;
		logic signed [63:0] ts, ta, tb, tmp;
		logic [63:0]        ut;
		if (en) begin
			cx_q[0]  <= cx_i;
			cz_q[0]  <= cz_i;
			acc_q[0] <= acc_i;
			for (int k = 1; k < L; k++) begin
				cx_q[k] <= cx_q[k-1];
				cz_q[k] <= cz_q[k-1];
			end
			for (int k = 1; k < L - 1; k++) acc_q[k] <= acc_q[k-1];

			// s1: hash products, fade first products
			hx_s1 <= cx_i[F +: 32] * fbmpn_pkg::HASH_MX;
			hz_s1 <= cz_i[F +: 32] * fbmpn_pkg::HASH_MZ;
			for (int k = 0; k < 2; k++) begin
				tt = (k == 0) ? cx_i[F-1:0] : cz_i[F-1:0];
				ts = $signed({{(64-F){1'b0}}, tt});
				ta = 6 * ts - 15 * ONE;
				tmp = ts * ta;
				pa_s1[k] <= tmp[2*F+5:0];
				pt_s1[k] <= tt * tt;
			end

			// s2: corner hash seeds, fade b and t^2
			nsum = hx_s1 + hz_s1;
			for (int c = 0; c < 4; c++) begin
				nn = nsum + fbmpn_pkg::corner_add(2'(c));
				n_s2[c] <= (nn << 13) ^ nn;
			end
			for (int k = 0; k < 2; k++) begin
				tmp = pa_s1[k];
				tmp = ((tmp + HALF) >>> F) + 10 * ONE;
				b_s2[k] <= tmp[BW-1:0];
				ut = 64'(pt_s1[k]) + HALFU;
				t2_s2[k] <= ut[2*F:F];
			end

			// s3
			for (int c = 0; c < 4; c++) begin
				sq_s3[c] <= n_s2[c] * n_s2[c];
				n_s3[c]  <= n_s2[c];
			end
			p3_s3[0] <= t2_s2[0] * cx_q[1][F-1:0];
			p3_s3[1] <= t2_s2[1] * cz_q[1][F-1:0];
			b_s3 <= b_s2;

			// s4
			for (int c = 0; c < 4; c++) begin
				u_s4[c] <= sq_s3[c] * fbmpn_pkg::HASH_C1 + fbmpn_pkg::HASH_C2;
				n_s4[c] <= n_s3[c];
			end
			for (int k = 0; k < 2; k++) begin
				ut = 64'(p3_s3[k]) + HALFU;
				t3_s4[k] <= ut[2*F:F];
			end
			b_s4 <= b_s3;

			// s5
			for (int c = 0; c < 4; c++) w_s5[c] <= n_s4[c] * u_s4[c];
			for (int k = 0; k < 2; k++) begin
				ts = $signed({{(63-F){1'b0}}, t3_s4[k]});
				tb = b_s4[k];
				tmp = ts * tb;
				pf_s5[k] <= tmp[2*F+7:0];
			end

			// s6: 31-bit hash, fade done
			for (int c = 0; c < 4; c++) begin
				nn = (w_s5[c] + fbmpn_pkg::HASH_C3) & fbmpn_pkg::HASH_MASK;
				e_s6[c] <= fbmpn_pkg::HASH_TOP - nn;
			end
			for (int k = 0; k < 2; k++) begin
				tmp = pf_s5[k];
				tmp = (tmp + HALF) >>> F;
				f_s6[k] <= tmp[FW-1:0];
			end

			// s7: (2^31 - m) * 25599 >> 31
			for (int c = 0; c < 4; c++) begin
				ut = 64'(e_s6[c]) * 64'(fbmpn_pkg::GRAD_PICK);
				v_s7[c] <= ut[46:31];
			end
			f_s7 <= f_s6;

			// s8: divide by 100, keep three bits
			for (int c = 0; c < 4; c++) begin
				ut = 64'(v_s7[c]) * 64'(fbmpn_pkg::RECIP100);
				idx_s8[c] <= ut[fbmpn_pkg::RECIP_SH +: 3];
			end
			f_s8 <= f_s7;

			// s9: gradient times offset
			for (int c = 0; c < 4; c++) begin
				ts = $signed({{(64-F){1'b0}}, cx_q[7][F-1:0]});
				if (c[0]) ts = ts - ONE;
				tb = fbmpn_pkg::grad_x(idx_s8[c]);
				tmp = tb * ts;
				px_s9[c] <= tmp[PW-1:0];
				ts = $signed({{(64-F){1'b0}}, cz_q[7][F-1:0]});
				if (c[1]) ts = ts - ONE;
				tb = fbmpn_pkg::grad_z(idx_s8[c]);
				tmp = tb * ts;
				pz_s9[c] <= tmp[PW-1:0];
			end
			f_s9 <= f_s8;

			// s10
			for (int c = 0; c < 4; c++) begin
				tmp = px_s9[c];
				tb  = pz_s9[c];
				tmp = (tmp + tb + HALF16) >>> 16;
				dot_s10[c] <= tmp[VW-1:0];
			end
			f_s10 <= f_s9;

			// s11: lerp along x
			for (int k = 0; k < 2; k++) begin
				tmp = dot_s10[2*k+1];
				tb  = dot_s10[2*k];
				tmp = tmp - tb;
				d_s11[k]    <= tmp[VW:0];
				base_s11[k] <= dot_s10[2*k];
			end
			f_s11 <= f_s10;

			// s12
			for (int k = 0; k < 2; k++) begin
				tmp = d_s11[k];
				tb  = f_s11[0];
				tmp = tmp * tb;
				m_s12[k] <= tmp[FW+VW:0];
			end
			base_s12 <= base_s11;
			fz_s12   <= f_s11[1];

			// s13
			for (int k = 0; k < 2; k++) begin
				tmp = m_s12[k];
				tb  = base_s12[k];
				tmp = tb + ((tmp + HALF) >>> F);
				r_s13[k] <= tmp[VW-1:0];
			end
			fz_s13 <= fz_s12;

			// s14: lerp along z
			tmp = r_s13[1];
			tb  = r_s13[0];
			tmp = tmp - tb;
			ta  = fz_s13;
			tmp = tmp * ta;
			mz_s14 <= tmp[FW+VW:0];
			r0_s14 <= r_s13[0];

			// s15
			tmp = mz_s14;
			tb  = r0_s14;
			tmp = tb + ((tmp + HALF) >>> F);
			r_s15 <= tmp[VW-1:0];

			// s16
			tmp = r_s15;
			tmp = tmp * $signed({47'd0, fbmpn_pkg::NOISE_SCALE});
			rn_s16 <= tmp[VW+17:0];

			// s17: Horner step, weight halves per octave
			tmp = rn_s16;
			tmp = (tmp + HALF16) >>> 16;
			tb  = acc_q[L-2];
			if (active) tb = (tb <<< 1) + tmp;
			acc_s17 <= tb[ACC_W-1:0];
		end
	end

	assign vld_o = vld_q[L-1];
	assign cx_o  = {cx_q[L-1][CW-2:0], 1'b0};
	assign cz_o  = {cz_q[L-1][CW-2:0], 1'b0};
	assign acc_o = acc_s17;

endmodule

[sv/fbmpn_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmpn_div_cell
// One restoring-division step: resolves one quotient bit per cell.
// ----------------------------------------------------------------------------
module fbmpn_div_cell #(
	parameter int UW  = 27,
	parameter int DW  = 8,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [DW-1:0] d,
	input  logic          vld_i,
	input  logic          neg_i,
	input  logic [UW-1:0] u_i,
	input  logic [DW-1:0] rem_i,
	input  logic [UW-1:0] q_i,
	output logic          vld_o,
	output logic          neg_o,
	output logic [UW-1:0] u_o,
	output logic [DW-1:0] rem_o,
	output logic [UW-1:0] q_o
);

	logic [DW:0] trial, diff;
	logic        ge;

	always_comb begin
		trial = {rem_i, u_i[BIT]};
		diff  = trial - {1'b0, d};
		ge    = trial >= {1'b0, d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_o <= neg_i;
			u_o   <= u_i;
			rem_o <= ge ? diff[DW-1:0] : trial[DW-1:0];
			q_o   <= {q_i[UW-2:0], ge};
		end
	end

endmodule

[sv/fbm_perlin_noise_2d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbm_perlin_noise_2d
// Fractal Brownian motion of 2D gradient noise, normalised to unsigned Q0.16.
// ----------------------------------------------------------------------------
// Takes one (x, z) sample per clock and returns one noise value per sample, in
// order. Each octave is a 17-stage cell in a chain, octaves beyond the effective
// octave count (octave_count held to 1..MAX_OCTAVES) pass the sum through
// unchanged, and the final division by the weight sum is a chain of
// restoring-division cells, one quotient bit each.
// Throughput is one transaction per cycle; the pipeline only stops while a
// result sits in the output register and m_tready is low. octave_count may
// only be written while the pipeline is empty.
// ----------------------------------------------------------------------------
module fbm_perlin_noise_2d #(
	parameter int MAX_OCTAVES = 8,
	parameter int FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] coord_x, [63:32] coord_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] noise_value
	output logic [0:0]  m_tuser,   // [0] clipped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data   // [3:0] octave_count
);

	localparam int F   = FRAC_BITS;
	localparam int CW  = F + 32;
	localparam int AW  = F + 4 + MAX_OCTAVES;
	localparam int DW  = MAX_OCTAVES;
	localparam int UW  = MAX_OCTAVES + 19;
	localparam logic [4:0] MAX_C = 5'(MAX_OCTAVES);

	logic [3:0]    oct_q;
	logic [3:0]    n_eff;
	logic [DW:0]   pow_n;
	logic [DW-1:0] d;
	logic          en;
	logic          last_vld;

	logic                 vld_w [MAX_OCTAVES+1];
	logic [CW-1:0]        cx_w  [MAX_OCTAVES+1];
	logic [CW-1:0]        cz_w  [MAX_OCTAVES+1];
	logic signed [AW-1:0] acc_w [MAX_OCTAVES+1];

	logic          dv_w  [UW+1];
	logic          dn_w  [UW+1];
	logic [UW-1:0] du_w  [UW+1];
	logic [DW-1:0] dr_w  [UW+1];
	logic [UW-1:0] dq_w  [UW+1];

	logic          norm_vld_s1;
	logic          neg_s1;
	logic [UW-1:0] u_s1;

	logic          out_vld_q;
	logic [15:0]   noise_q;
	logic          clip_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q <= fbmpn_pkg::OCT_RESET;
		end else if (cfg_valid) begin
			oct_q <= cfg_data;
		end
	end

	always_comb begin
		if (oct_q == 4'd0) n_eff = 4'd1;
		else if ({1'b0, oct_q} > MAX_C) n_eff = MAX_C[3:0];
		else n_eff = oct_q;
		pow_n = (DW + 1)'(1) << n_eff;
		d     = DW'(pow_n - 1'b1);
	end

	// flow control: stall only when a result would overwrite an untaken one
	assign last_vld = dv_w[UW];
	assign en       = !last_vld || !out_vld_q || m_tready;
	assign s_tready = en;

	// octave chain
	assign vld_w[0] = s_tvalid && en;
	assign cx_w[0]  = CW'($signed(s_tdata[31:0]));
	assign cz_w[0]  = CW'($signed(s_tdata[63:32]));
	assign acc_w[0] = '0;

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
		fbmpn_octave_cell #(
			.FRAC_BITS(F),
			.ACC_W    (AW),
			.OCT_IDX  (i),
			.OCT_W    (4)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.oct_cnt(n_eff),
			.vld_i  (vld_w[i]),
			.cx_i   (cx_w[i]),
			.cz_i   (cz_w[i]),
			.acc_i  (acc_w[i]),
			.vld_o  (vld_w[i+1]),
			.cx_o   (cx_w[i+1]),
			.cz_o   (cz_w[i+1]),
			.acc_o  (acc_w[i+1])
		);
	end

	// (acc * 2^15 + den / 2) >> F, then split into sign and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_vld_s1 <= 1'b0;
		end else if (en) begin
			norm_vld_s1 <= vld_w[MAX_OCTAVES];
		end
	end

	always_ff @(posedge clk) begin : p_norm
		logic signed [63:0] pre, dd;
		if (en) begin
			pre = acc_w[MAX_OCTAVES];
			dd  = $signed({{(64-DW){1'b0}}, d});
			pre = ((pre <<< 15) + (dd <<< (F - 1))) >>> F;
			neg_s1 <= pre[63];
			u_s1   <= pre[63] ? ~pre[UW-1:0] : pre[UW-1:0];
		end
	end

	// divide by (2^n - 1)
	assign dv_w[0] = norm_vld_s1;
	assign dn_w[0] = neg_s1;
	assign du_w[0] = u_s1;
	assign dr_w[0] = '0;
	assign dq_w[0] = '0;

	for (genvar j = 0; j < UW; j++) begin : g_div
		fbmpn_div_cell #(
			.UW (UW),
			.DW (DW),
			.BIT(UW - 1 - j)
		) u_div (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.d     (d),
			.vld_i (dv_w[j]),
			.neg_i (dn_w[j]),
			.u_i   (du_w[j]),
			.rem_i (dr_w[j]),
			.q_i   (dq_w[j]),
			.vld_o (dv_w[j+1]),
			.neg_o (dn_w[j+1]),
			.u_o   (du_w[j+1]),
			.rem_o (dr_w[j+1]),
			.q_o   (dq_w[j+1])
		);
	end

	// output register: offset, saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			if (en && last_vld) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin : p_out
		logic signed [63:0] q;
		if (en && last_vld) begin
			q = $signed({{(64-UW){1'b0}}, dq_w[UW]});
			if (dn_w[UW]) q = -q - 64'sd1;
			q = q + 64'sd32768;
			if (q < 64'sd0) begin
				noise_q <= 16'd0;
				clip_q  <= 1'b1;
			end else if (q > 64'sd65535) begin
				noise_q <= 16'hffff;
				clip_q  <= 1'b1;
			end else begin
				noise_q <= q[15:0];
				clip_q  <= 1'b0;
			end
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = noise_q;
	assign m_tuser[0] = clip_q;

`ifndef SYNTHESIS
	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 16'd0 || m_tdata == 16'hffff))
		else $error("clipped result not at a rail");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready && last_vld)
		else $error("pipeline stalled without a waiting result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		en && last_vld |=> m_tvalid)
		else $error("finished transaction not presented");

	a_oct_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_eff != 4'd0 && {1'b0, n_eff} <= MAX_C)
		else $error("effective octave count out of range");
`endif

endmodule

[verif/tb_fbm_perlin_noise_2d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fbm_perlin_noise_2d
// Self-checking bench for the fBm gradient noise pipeline.
// ----------------------------------------------------------------------------
// Sends (x, z) samples in phases with different octave counts and compares
// every noise result with a bit-exact fixed-point predictor kept in the bench.
// Both stream sides get random gaps, and one long output stall halts the
// pipeline. A watchdog ends the run when nothing moves for too long.
// ----------------------------------------------------------------------------
module tb_fbm_perlin_noise_2d;

	localparam int MAX_OCT   = 8;
	localparam int LATENCY   = 17 * MAX_OCT + MAX_OCT + 21;
	localparam int WDOG_MAX  = 20000;
	localparam longint ONE_Q = 64'sd65536;

	typedef struct packed {
		logic [31:0] z;
		logic [31:0] x;
	} sample_t;

	typedef struct packed {
		logic [15:0] value;
		logic        clip;
	} noise_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;

	fbm_perlin_noise_2d dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	sample_t sample_q[$];
	noise_t  noise_q[$];
	logic [3:0] oct_setting;
	int  sent, received, mismatches, idle_cycles;
	int  hold_off;
	bit  stall_req;
	bit  s_acc;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------- predictor ----------------
	function automatic longint rshift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic int pick_grad(logic [31:0] cx, logic [31:0] cz);
		logic [31:0] n, m;
		logic [63:0] prod;
		n = cx * 32'd1619 + cz * 32'd31337;
		n = (n << 13) ^ n;
		m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
		prod = (64'h8000_0000 - {32'd0, m}) * 64'd25599;
		return int'((prod / (64'd100 << 31)) & 64'd7);
	endfunction

	function automatic longint corner(logic [31:0] cx, logic [31:0] cz,
			longint dx, longint dz);
		int h;
		longint gx, gz;
		h = pick_grad(cx, cz);
		case (h)
			0: begin gx = 65536; gz = 0; end
			1: begin gx = -65536; gz = 0; end
			2: begin gx = 0; gz = 65536; end
			3: begin gx = 0; gz = -65536; end
			4: begin gx = 46341; gz = 46341; end
			5: begin gx = -46341; gz = 46341; end
			6: begin gx = 46341; gz = -46341; end
			default: begin gx = -46341; gz = -46341; end
		endcase
		return rshift(gx * dx + gz * dz, 16);
	endfunction

	function automatic longint quintic(longint t);
		longint a, b, t2, t3;
		a = 6 * t - 15 * ONE_Q;
		b = rshift(t * a, 16) + 10 * ONE_Q;
		t2 = rshift(t * t, 16);
		t3 = rshift(t2 * t, 16);
		return rshift(t3 * b, 16);
	endfunction

	function automatic longint octave_noise(longint px, longint pz);
		logic [31:0] xi, zi;
		longint tx, tz, fx, fz, v00, v10, v01, v11, r0, r1, r;
		xi = 32'(px >>> 16);
		zi = 32'(pz >>> 16);
		tx = px & 64'hffff;
		tz = pz & 64'hffff;
		fx = quintic(tx);
		fz = quintic(tz);
		v00 = corner(xi, zi, tx, tz);
		v10 = corner(xi + 1, zi, tx - ONE_Q, tz);
		v01 = corner(xi, zi + 1, tx, tz - ONE_Q);
		v11 = corner(xi + 1, zi + 1, tx - ONE_Q, tz - ONE_Q);
		r0 = v00 + rshift(fx * (v10 - v00), 16);
		r1 = v01 + rshift(fx * (v11 - v01), 16);
		r = r0 + rshift(fz * (r1 - r0), 16);
		return rshift(r * 92681, 16);
	endfunction

	function automatic noise_t fbm_expect(sample_t s, logic [3:0] oct);
		longint x, z, acc, den, num, q;
		int n;
		noise_t res;
		x = longint'(signed'(s.x));
		z = longint'(signed'(s.z));
		n = (oct < 1) ? 1 : (oct > MAX_OCT) ? MAX_OCT : oct;
		acc = 0;
		for (int i = 0; i < n; i++)
			acc += octave_noise(x <<< i, z <<< i) <<< (n - 1 - i);
		den = ((64'sd1 <<< n) - 1) * ONE_Q;
		num = acc * 32768 + den / 2;
		q = (num >= 0) ? num / den : -((-(num + 1)) / den) - 1;
		q = q + 32768;
		res.clip = 1'b0;
		if (q < 0) begin
			q = 0;
			res.clip = 1'b1;
		end else if (q > 65535) begin
			q = 65535;
			res.clip = 1'b1;
		end
		res.value = q[15:0];
		return res;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// ---------------- driver ----------------
	// s_acc holds whether the last rising edge took the offered transaction
	int s_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_gap    <= 0;
		end else if (!s_tvalid || s_acc) begin
			if (s_gap > 0) begin
				s_gap    <= s_gap - 1;
				s_tvalid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= sample_q.pop_front();
				s_gap    <= gap_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// predictions made at the accept edge against the current setting
	always @(posedge clk) begin
		s_acc <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			noise_q.insert(noise_q.size(), fbm_expect(sample_t'(s_tdata), oct_setting));
			sent++;
		end
	end

	// receiver readiness, with a long counted hold-off on request
	int m_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_gap    <= 0;
			hold_off <= 0;
		end else if (stall_req && hold_off == 0 && m_gap == 0) begin
			hold_off <= 400;
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= (hold_off == 1);
		end else if (m_gap > 0) begin
			m_gap    <= m_gap - 1;
			m_tready <= (m_gap == 1);
		end else begin
			m_gap    <= gap_len();
			m_tready <= 1'b1;
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		noise_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			received++;
			if (noise_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%0d clipped=%0b", m_tdata, m_tuser);
			end else begin
				exp_r = noise_q.pop_front();
				if (m_tdata !== exp_r.value || m_tuser[0] !== exp_r.clip) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: value exp %0d got %0d, clipped exp %0b got %0b",
							received, exp_r.value, m_tdata, exp_r.clip, m_tuser[0]);
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready) || hold_off > 0)
			idle_cycles <= 0;
		else if (sample_q.size() > 0 || noise_q.size() > 0 || s_tvalid || cfg_valid) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_MAX) begin
				$display("watchdog: no transaction for %0d cycles", WDOG_MAX);
				$display("FAIL fbm_perlin_noise_2d");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------
	task automatic write_octaves(logic [3:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		oct_setting = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sample_q.size() > 0 || s_tvalid || noise_q.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
			2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
			3: return {16'($urandom_range(0, 64)), 16'($urandom())};
			4: return $urandom_range(0, 1) ? 32'h7fff_ffff - 32'($urandom_range(0, 255))
				: 32'h8000_0000 + 32'($urandom_range(0, 255));
			default: return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom())};
		endcase
	endfunction

	task automatic add_sample(logic [31:0] x, logic [31:0] z);
		sample_t s;
		s.x = x;
		s.z = z;
		sample_q.insert(sample_q.size(), s);
	endtask

	logic [3:0] oct_plan[7] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5};

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		stall_req = 1'b0;
		oct_setting = fbmpn_pkg::OCT_RESET;
		sent = 0;
		received = 0;
		mismatches = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: corners of the coordinate range, lattice points, cell edges
		add_sample(32'h0000_0000, 32'h0000_0000);
		add_sample(32'h7fff_ffff, 32'h7fff_ffff);
		add_sample(32'h8000_0000, 32'h8000_0000);
		add_sample(32'h7fff_ffff, 32'h8000_0000);
		add_sample(32'h8000_0000, 32'h7fff_ffff);
		add_sample(32'hffff_ffff, 32'hffff_ffff);
		add_sample(32'h0000_ffff, 32'h0000_8000);
		add_sample(32'h0001_0000, 32'hffff_0000);
		add_sample(32'h0000_8000, 32'h0000_8000);
		add_sample(32'hffff_8000, 32'h0000_0001);
		add_sample(32'h5555_5555, 32'haaaa_aaaa);
		add_sample(32'haaaa_aaaa, 32'h5555_5555);
		drain();

		// random phases over octave settings, including zero and above the max
		for (int p = 0; p < 7; p++) begin
			write_octaves(oct_plan[p]);
			if (p == 3)
				stall_req = 1'b1;
			for (int i = 0; i < 90; i++)
				add_sample(rand_coord(), rand_coord());
			while (sample_q.size() > 60) @(posedge clk);
			stall_req = 1'b0;
			drain();
		end

		$display("covered %0d samples over octave counts 4,1,8,0,15,3,9,5", sent);
		$display("extreme coordinates, random gaps and a long output stall included");
		if (mismatches == 0 && received == sent)
			$display("PASS fbm_perlin_noise_2d");
		else
			$display("FAIL fbm_perlin_noise_2d");
		$finish;
	end

endmodule

[fbm_perlin_noise_2d.f]
sv/fbmpn_pkg.sv
sv/fbmpn_octave_cell.sv
sv/fbmpn_div_cell.sv
sv/fbm_perlin_noise_2d.sv
verif/tb_fbm_perlin_noise_2d.sv
